@@ rtl/core/ccs_pkg.sv @@
// Package for the cleaning cycle sequencer: phase codes, register indexes,
// item and state types, and the elapsed-time helper.
// No dependencies; imported by every module of the block.
package ccs_pkg;

    // Sequence phases, in the order one pass runs through them.
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_FILL_START = 4'd1,
        PH_FILL_WAIT  = 4'd2,
        PH_ULTRA_ON   = 4'd3,
        PH_ULTRA_WAIT = 4'd4,
        PH_DRAIN_ON   = 4'd5,
        PH_DRAIN_WAIT = 4'd6,
        PH_DRAIN_HOLD = 4'd7,
        PH_PASS_DONE  = 4'd8
    } phase_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MOTOR_TIME      = 3'd0,
        REG_FILL_TIMEOUT    = 3'd1,
        REG_ULTRASONIC_TIME = 3'd2,
        REG_DRAIN_TIMEOUT   = 3'd3,
        REG_DRAIN_DELAY     = 3'd4,
        REG_PASS_TOTAL      = 3'd5
    } cfg_reg_t;

    // Door event codes.
    localparam logic [1:0] DOOR_NONE   = 2'd0;
    localparam logic [1:0] DOOR_OPENED = 2'd1;
    localparam logic [1:0] DOOR_CLOSED = 2'd2;

    // Bit positions in the drive vector.
    localparam int DRV_FILL  = 0;
    localparam int DRV_MOTOR = 1;
    localparam int DRV_ULTRA = 2;
    localparam int DRV_DRAIN = 3;

    // Reset values of the configuration registers.
    localparam logic [31:0] MOTOR_TIME_RST      = 32'd3000;
    localparam logic [31:0] FILL_TIMEOUT_RST    = 32'd6000;
    localparam logic [31:0] ULTRASONIC_TIME_RST = 32'd6000;
    localparam logic [31:0] DRAIN_TIMEOUT_RST   = 32'd30000;
    localparam logic [31:0] DRAIN_DELAY_RST     = 32'd10000;
    localparam logic [7:0]  PASS_TOTAL_RST      = 8'd1;

    typedef struct packed {
        logic [31:0] motor_time;
        logic [31:0] fill_timeout;
        logic [31:0] ultrasonic_time;
        logic [31:0] drain_timeout;
        logic [31:0] drain_delay;
        logic [7:0]  pass_total;
    } ccs_cfg_t;

    typedef struct packed {
        logic [31:0] time_now;
        logic        level_low;
        logic        level_high;
        logic        door_open;
        logic        start_req;
    } ccs_item_t;

    typedef struct packed {
        logic       finished;
        logic [1:0] door_event;
        logic [3:0] phase;
        logic [3:0] drives;
    } ccs_result_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  pass_count;
        logic        door_prev;
        logic [31:0] mark_fill;
        logic [31:0] mark_phase;
        logic [3:0]  drives;
    } ccs_state_t;

    // True once at least limit ticks have gone by since mark, modulo 2^32.
    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] mark,
                                     input logic [31:0] limit);
        logic [31:0] diff;
        diff = now - mark;
        return diff >= limit;
    endfunction

endpackage

@@ rtl/core/cleaning_cycle_sequencer.sv @@
// Cleaning cycle sequencer: timed washer cycle, one call per input item.
// An accepted item is held in the item register, which feeds the sequence step
// into the result register, from which the result is offered.
// Throughput: one item per cycle when results drain; the step is combinational.
// Reset: rst_n is asynchronous, active low; the sequence goes idle with all
// drives off and the configuration registers take their default values.
module cleaning_cycle_sequencer
    import ccs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input items.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Bits: start_req, door_open, level_high, level_low, time_now[31:0], zero pad.
    input  logic [39:0]            s_tdata,
    // Result items.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Bits: fill_valve_on, motor_on, ultrasonic_on, drain_valve_on, phase[3:0],
    // door_event[1:0], finished, zero pad.
    output logic [15:0]            m_tdata,
    // Configuration writes.
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    ccs_cfg_t    cfg;
    ccs_item_t   item_reg;
    logic        item_valid_reg;
    ccs_state_t  state_reg;
    ccs_state_t  state_next;
    ccs_result_t res_next;
    ccs_result_t res_reg;
    logic        res_valid_reg;
    logic        advance;

    ccs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccs_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // The held item moves on when the result register is free or being drained.
    assign advance  = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    // Input item register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= ccs_item_t'(s_tdata[35:0]);
        end
    end

    // Sequence state, updated once for every processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_IDLE;
            state_reg.pass_count <= 8'd0;
            state_reg.door_prev  <= 1'b1;
            state_reg.mark_fill  <= 32'd0;
            state_reg.mark_phase <= 32'd0;
            state_reg.drives     <= 4'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {5'd0, res_reg};

`ifndef SYNTHESIS
    // A finishing step always leaves the sequence idle.
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.finished |-> res_reg.phase == PH_IDLE)
        else $error("finished reported outside idle");

    // An item seen with the door open never finishes a cycle.
    a_door_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.door_open |=> !res_reg.finished)
        else $error("finished while door open");

    // Any active phase belongs to a started pass.
    a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PH_IDLE |-> state_reg.pass_count != 8'd0)
        else $error("active phase with zero pass count");

    // Input is refused only while an item is held back.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> item_valid_reg && res_valid_reg && !m_tready)
        else $error("input stalled without cause");
`endif

endmodule

@@ rtl/core/ccs_cfg_regs.sv @@
// Configuration register file of the cleaning cycle sequencer.
// Depends on ccs_pkg for the register indexes and the config struct.
module ccs_cfg_regs
    import ccs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output ccs_cfg_t               cfg
);

    ccs_cfg_t cfg_reg;

    // Write one register per enabled cycle; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_time      <= MOTOR_TIME_RST;
            cfg_reg.fill_timeout    <= FILL_TIMEOUT_RST;
            cfg_reg.ultrasonic_time <= ULTRASONIC_TIME_RST;
            cfg_reg.drain_timeout   <= DRAIN_TIMEOUT_RST;
            cfg_reg.drain_delay     <= DRAIN_DELAY_RST;
            cfg_reg.pass_total      <= PASS_TOTAL_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_MOTOR_TIME:      cfg_reg.motor_time      <= cfg_data;
                REG_FILL_TIMEOUT:    cfg_reg.fill_timeout    <= cfg_data;
                REG_ULTRASONIC_TIME: cfg_reg.ultrasonic_time <= cfg_data;
                REG_DRAIN_TIMEOUT:   cfg_reg.drain_timeout   <= cfg_data;
                REG_DRAIN_DELAY:     cfg_reg.drain_delay     <= cfg_data;
                REG_PASS_TOTAL:      cfg_reg.pass_total      <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/ccs_step.sv @@
// Next-state logic of the cleaning cycle sequencer: one call of the
// sequence, walking through every phase that can advance in this step.
// Depends on ccs_pkg for types, phase codes and the elapsed helper.
module ccs_step
    import ccs_pkg::*;
(
    input  ccs_cfg_t    cfg,
    input  ccs_state_t  cur,
    input  ccs_item_t   item,
    output ccs_state_t  nxt,
    output ccs_result_t res
);

    always_comb
    begin
        ccs_state_t s;
        logic [1:0] ev;
        logic       fin;
        logic       go;

        s   = cur;
        ev  = DOOR_NONE;
        fin = 1'b0;

        // A start restarts at the first pass and treats the door as closed.
        if (item.start_req)
        begin
            s.door_prev  = 1'b0;
            s.phase      = PH_FILL_START;
            s.pass_count = 8'd1;
        end

        // Door edge report; an open door holds the sequence.
        if (item.door_open != s.door_prev)
        begin
            ev = item.door_open ? DOOR_OPENED : DOOR_CLOSED;
        end
        s.door_prev = item.door_open;
        go = !item.door_open;

        // Fill and motor on.
        if (go && s.phase == PH_FILL_START)
        begin
            s.drives[DRV_FILL]  = 1'b1;
            s.drives[DRV_MOTOR] = 1'b1;
            s.mark_fill         = item.time_now;
            s.phase             = PH_FILL_WAIT;
        end

        // Motor stops after its time; once it has, fill ends on timeout or full tank.
        if (go && s.phase == PH_FILL_WAIT)
        begin
            go = 1'b0;
            if (elapsed(item.time_now, s.mark_fill, cfg.motor_time))
            begin
                s.drives[DRV_MOTOR] = 1'b0;
                if (elapsed(item.time_now, s.mark_fill, cfg.fill_timeout) ||
                    item.level_high)
                begin
                    s.drives[DRV_FILL] = 1'b0;
                    s.phase            = PH_ULTRA_ON;
                    go                 = 1'b1;
                end
            end
        end

        // Ultrasonic on.
        if (go && s.phase == PH_ULTRA_ON)
        begin
            s.drives[DRV_ULTRA] = 1'b1;
            s.mark_phase        = item.time_now;
            s.phase             = PH_ULTRA_WAIT;
        end

        // Ultrasonic runs for its set time.
        if (go && s.phase == PH_ULTRA_WAIT)
        begin
            go = 1'b0;
            if (elapsed(item.time_now, s.mark_phase, cfg.ultrasonic_time))
            begin
                s.drives[DRV_ULTRA] = 1'b0;
                s.phase             = PH_DRAIN_ON;
                go                  = 1'b1;
            end
        end

        // Drain valve opens.
        if (go && s.phase == PH_DRAIN_ON)
        begin
            s.drives[DRV_DRAIN] = 1'b1;
            s.mark_phase        = item.time_now;
            s.phase             = PH_DRAIN_WAIT;
        end

        // Drain until the low switch or the timeout.
        if (go && s.phase == PH_DRAIN_WAIT)
        begin
            go = 1'b0;
            if (item.level_low ||
                elapsed(item.time_now, s.mark_phase, cfg.drain_timeout))
            begin
                s.mark_fill = item.time_now;
                s.phase     = PH_DRAIN_HOLD;
                go          = 1'b1;
            end
        end

        // Keep the drain open a little longer.
        if (go && s.phase == PH_DRAIN_HOLD)
        begin
            go = 1'b0;
            if (elapsed(item.time_now, s.mark_fill, cfg.drain_delay))
            begin
                s.drives[DRV_DRAIN] = 1'b0;
                s.phase             = PH_PASS_DONE;
                go                  = 1'b1;
            end
        end

        // Next pass, or finish and go idle.
        if (go && s.phase == PH_PASS_DONE)
        begin
            if (s.pass_count < cfg.pass_total)
            begin
                s.pass_count = s.pass_count + 8'd1;
                s.phase      = PH_FILL_START;
            end
            else
            begin
                fin     = 1'b1;
                s.phase = PH_IDLE;
            end
        end

        nxt            = s;
        res.drives     = s.drives;
        res.phase      = s.phase;
        res.door_event = ev;
        res.finished   = fin;
    end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the cleaning cycle sequencer.
// Items are driven from a queue and the results are checked against a built-in model.
// Depends on ccs_pkg and the cleaning_cycle_sequencer RTL.
`timescale 1ns / 1ps

module testbench;
    import ccs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // Bits: start_req, door_open, level_high, level_low, time_now[31:0], zero pad.
    logic [39:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // Bits: fill_valve_on, motor_on, ultrasonic_on, drain_valve_on, phase[3:0],
    // door_event[1:0], finished, zero pad.
    logic [15:0]            m_tdata;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    cleaning_cycle_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and checking bookkeeping.
    ccs_item_t   pending_calls[$];
    ccs_result_t expected_outputs[$];
    logic        feed_en = 1'b0;
    logic        item_taken = 1'b0;
    int          send_gap_pct = 9;
    int          stall_pct = 69;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic [31:0] tick;

    // Shadow copy of the configuration registers.
    logic [31:0] motor_ticks;
    logic [31:0] fill_limit;
    logic [31:0] ultra_ticks;
    logic [31:0] drain_limit;
    logic [31:0] drain_hold;
    logic [7:0]  passes_wanted;

    // Shadow copy of the sequencer state.
    phase_t      wash_phase;
    logic [7:0]  passes_done;
    logic        door_last;
    logic [31:0] fill_mark;
    logic [31:0] phase_mark;
    logic [3:0]  valves;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] ticks_since(input logic [31:0] now,
                                                input logic [31:0] mark);
        ticks_since = now - mark;
    endfunction

    // One washer call: advance the shadow state and return the outputs it shows.
    function automatic ccs_result_t step_washer(input ccs_item_t call);
        ccs_result_t outs;
        logic        run;
        logic [31:0] now;
        outs = '0;
        now = call.time_now;
        if (call.start_req)
        begin
            door_last = 1'b0;
            wash_phase = PH_FILL_START;
            passes_done = 8'd1;
        end
        if (call.door_open != door_last)
            outs.door_event = call.door_open ? DOOR_OPENED : DOOR_CLOSED;
        door_last = call.door_open;
        run = !call.door_open;

        if (run && wash_phase == PH_FILL_START)
        begin
            valves[DRV_FILL] = 1'b1;
            valves[DRV_MOTOR] = 1'b1;
            fill_mark = now;
            wash_phase = PH_FILL_WAIT;
        end
        if (run && wash_phase == PH_FILL_WAIT)
        begin
            run = 1'b0;
            if (ticks_since(now, fill_mark) >= motor_ticks)
            begin
                valves[DRV_MOTOR] = 1'b0;
                if (ticks_since(now, fill_mark) >= fill_limit || call.level_high)
                begin
                    valves[DRV_FILL] = 1'b0;
                    wash_phase = PH_ULTRA_ON;
                    run = 1'b1;
                end
            end
        end
        if (run && wash_phase == PH_ULTRA_ON)
        begin
            valves[DRV_ULTRA] = 1'b1;
            phase_mark = now;
            wash_phase = PH_ULTRA_WAIT;
        end
        if (run && wash_phase == PH_ULTRA_WAIT)
        begin
            run = 1'b0;
            if (ticks_since(now, phase_mark) >= ultra_ticks)
            begin
                valves[DRV_ULTRA] = 1'b0;
                wash_phase = PH_DRAIN_ON;
                run = 1'b1;
            end
        end
        if (run && wash_phase == PH_DRAIN_ON)
        begin
            valves[DRV_DRAIN] = 1'b1;
            phase_mark = now;
            wash_phase = PH_DRAIN_WAIT;
        end
        if (run && wash_phase == PH_DRAIN_WAIT)
        begin
            run = 1'b0;
            if (call.level_low || ticks_since(now, phase_mark) >= drain_limit)
            begin
                fill_mark = now;
                wash_phase = PH_DRAIN_HOLD;
                run = 1'b1;
            end
        end
        if (run && wash_phase == PH_DRAIN_HOLD)
        begin
            run = 1'b0;
            if (ticks_since(now, fill_mark) >= drain_hold)
            begin
                valves[DRV_DRAIN] = 1'b0;
                wash_phase = PH_PASS_DONE;
                run = 1'b1;
            end
        end
        // A finished pass either loops back for another one or ends the cycle.
        if (run && wash_phase == PH_PASS_DONE)
        begin
            if (passes_done < passes_wanted)
            begin
                passes_done = passes_done + 8'd1;
                wash_phase = PH_FILL_START;
            end
            else
            begin
                outs.finished = 1'b1;
                wash_phase = PH_IDLE;
            end
        end

        outs.drives = valves;
        outs.phase = wash_phase;
        return outs;
    endfunction

    // Driver: inputs change on the falling edge; an offered item is held until taken.
    always @(negedge clk)
    begin
        if (s_tvalid && !item_taken)
        begin
            // Keep the current item on the bus.
        end
        else if (feed_en && pending_calls.size() > 0 && $urandom_range(99) >= send_gap_pct)
        begin
            s_tvalid <= 1'b1;
            s_tdata <= {4'b0000, pending_calls[0]};
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predicts on each accepted item and checks each accepted result.
    always @(posedge clk)
    begin
        ccs_result_t got;
        ccs_result_t want;
        item_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("cleaning_cycle_sequencer verification failed");
                $finish;
            end
            if (s_tvalid && s_tready)
            begin
                expected_outputs.push_back(step_washer(ccs_item_t'(s_tdata[35:0])));
                void'(pending_calls.pop_front());
            end
            if (m_tvalid && m_tready)
            begin
                got = ccs_result_t'(m_tdata[10:0]);
                if (expected_outputs.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected result %h with nothing pending", m_tdata);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (got.drives !== want.drives || got.phase !== want.phase ||
                        got.door_event !== want.door_event ||
                        got.finished !== want.finished || m_tdata[15:11] !== 5'b0)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < REPORT_MAX)
                            $display({"result mismatch: drives %b/%b phase %0d/%0d ",
                                      "door_event %0d/%0d finished %b/%b pad %b (exp/act)"},
                                     want.drives, got.drives, want.phase, got.phase,
                                     want.door_event, got.door_event,
                                     want.finished, got.finished, m_tdata[15:11]);
                    end
                end
            end
        end
    end

    task automatic push_call(input logic start, input logic door, input logic high,
                             input logic low, input logic [31:0] now);
        ccs_item_t call;
        call.start_req = start;
        call.door_open = door;
        call.level_high = high;
        call.level_low = low;
        call.time_now = now;
        pending_calls.push_back(call);
    endtask

    // Wait until every item is taken and every result is back, then let the pipe settle.
    task automatic wait_idle();
        while (pending_calls.size() > 0 || s_tvalid || expected_outputs.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_MOTOR_TIME:      motor_ticks = value;
            REG_FILL_TIMEOUT:    fill_limit = value;
            REG_ULTRASONIC_TIME: ultra_ticks = value;
            REG_DRAIN_TIMEOUT:   drain_limit = value;
            REG_DRAIN_DELAY:     drain_hold = value;
            REG_PASS_TOTAL:      passes_wanted = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_timers(input logic [31:0] motor, input logic [31:0] fill,
                              input logic [31:0] ultra, input logic [31:0] drain,
                              input logic [31:0] hold, input logic [31:0] passes);
        write_reg(REG_MOTOR_TIME, motor);
        write_reg(REG_FILL_TIMEOUT, fill);
        write_reg(REG_ULTRASONIC_TIME, ultra);
        write_reg(REG_DRAIN_TIMEOUT, drain);
        write_reg(REG_DRAIN_DELAY, hold);
        write_reg(REG_PASS_TOTAL, passes);
    endtask

    // Queue wash runs: a start followed by calls with advancing time and random
    // switches, with some door openings, stray starts and backward time steps.
    task automatic queue_runs(input int total, input int step_max, input int run_min,
                              input int run_max);
        int added;
        int run_len;
        int roll;
        added = 0;
        while (added < total)
        begin
            push_call(1'b1, $urandom_range(99) < 10, 1'($urandom_range(1)),
                      1'($urandom_range(1)), tick);
            added++;
            run_len = $urandom_range(run_max, run_min);
            for (int k = 0; k < run_len && added < total; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    tick = tick - 32'd1;
                else if (roll < 6)
                    tick = $urandom;
                else
                    tick = tick + $urandom_range(step_max, 0);
                push_call($urandom_range(99) < 2, $urandom_range(99) < 8,
                          $urandom_range(99) < 25, $urandom_range(99) < 25, tick);
                added++;
            end
        end
    endtask

    initial
    begin
        motor_ticks = MOTOR_TIME_RST;
        fill_limit = FILL_TIMEOUT_RST;
        ultra_ticks = ULTRASONIC_TIME_RST;
        drain_limit = DRAIN_TIMEOUT_RST;
        drain_hold = DRAIN_DELAY_RST;
        passes_wanted = PASS_TOTAL_RST;
        wash_phase = PH_IDLE;
        passes_done = 8'd0;
        door_last = 1'b1;
        fill_mark = '0;
        phase_mark = '0;
        valves = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        feed_en = 1'b1;

        // Directed calls at the default timing: a closed door on the first call,
        // a start with the door open, a held sequence, one full pass and the finish.
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
        push_call(1'b1, 1'b1, 1'b0, 1'b0, 32'd10);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'd20);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'd3020);
        push_call(1'b0, 1'b1, 1'b1, 1'b0, 32'd3021);
        push_call(1'b0, 1'b0, 1'b1, 1'b0, 32'd3021);
        push_call(1'b0, 1'b0, 1'b0, 1'b1, 32'd9021);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'd19021);
        push_call(1'b0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // Fill timeout across the wrap of the tick count, then drain timeout.
        push_call(1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_1770);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_2EE0);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_2EE0 + 32'd30000);
        push_call(1'b1, 1'b0, 1'b1, 1'b1, 32'h0000_2EE0 + 32'd30001);
        wait_idle();

        // Zero timing with two passes: the second pass loops back from pass done.
        set_timers(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2);
        push_call(1'b1, 1'b0, 1'b0, 1'b0, 32'd5);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'd5);
        push_call(1'b0, 1'b0, 1'b0, 1'b0, 32'd6);
        wait_idle();

        // A pass total of zero ends the cycle after one pass.
        write_reg(REG_PASS_TOTAL, 32'd0);
        push_call(1'b1, 1'b0, 1'b1, 1'b0, 32'd7);
        push_call(1'b0, 1'b1, 1'b0, 1'b0, 32'd8);
        wait_idle();

        // Random batches, each with its own timing and idling pattern.
        for (int b = 0; b < 8; b++)
        begin
            send_gap_pct = (b < 3) ? 9 : (b < 6) ? 69 : 0;
            stall_pct = (b < 3) ? 69 : (b < 6) ? 9 : 0;
            tick = $urandom;
            case (b)
                0, 3, 6:
                begin
                    set_timers($urandom_range(12), $urandom_range(12), $urandom_range(12),
                               $urandom_range(12), $urandom_range(12), $urandom_range(4, 1));
                    queue_runs(60, 6, 4, 30);
                end
                1:
                begin
                    set_timers(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd255);
                    queue_runs(270, 0, 265, 270);
                end
                2:
                begin
                    set_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
                    queue_runs(50, 3, 4, 20);
                end
                4:
                begin
                    set_timers(MOTOR_TIME_RST, FILL_TIMEOUT_RST, ULTRASONIC_TIME_RST,
                               DRAIN_TIMEOUT_RST, DRAIN_DELAY_RST, 32'(PASS_TOTAL_RST));
                    queue_runs(60, 4000, 4, 30);
                end
                5:
                begin
                    set_timers($urandom_range(1) ? $urandom : $urandom_range(20),
                               $urandom_range(1) ? $urandom : $urandom_range(20),
                               $urandom_range(1) ? $urandom : $urandom_range(20),
                               $urandom_range(1) ? $urandom : $urandom_range(20),
                               $urandom_range(1) ? $urandom : $urandom_range(20),
                               $urandom_range(8, 1));
                    queue_runs(50, 10, 4, 25);
                end
                default:
                begin
                    set_timers($urandom_range(8), $urandom_range(8), $urandom_range(8),
                               $urandom_range(8), $urandom_range(8), $urandom_range(2, 1));
                    queue_runs(60, 5, 4, 30);
                end
            endcase
            wait_idle();
        end

        if (mismatch_count == 0 && expected_outputs.size() == 0)
            $display("cleaning_cycle_sequencer verification clean");
        else
            $display("cleaning_cycle_sequencer verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ccs_pkg.sv
rtl/core/ccs_cfg_regs.sv
rtl/core/ccs_step.sv
rtl/core/cleaning_cycle_sequencer.sv
test/testbench.sv
